/* rtl/cubic_hermite_interpolator_defines.svh */
// Assertion macros used by the interpolator top level
`ifndef CUBIC_HERMITE_INTERPOLATOR_DEFINES_SVH
`define CUBIC_HERMITE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, held off during reset
`define CHI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define CHI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/chi_pkg.sv */
// Package: constants, register codes and stage control types of the interpolator
`default_nettype none
package chi_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TENSION = 2'd1;

    localparam logic signed [CFG_DATA_W-1:0] Q14_ONE = 16'sd16384;

    localparam int WGT_W      = 18;  // 1 +/- Q1.14 value, 0..32768, signed
    localparam int COEF_FRAC  = 12;  // fractional bits of the polynomial coefficients
    localparam int TAN_SHIFT  = 17;  // Q14 * Q14 * 2 down to Q12
    localparam int COEF_XW    = 18;  // coefficient width above the sample width
    localparam int ACC_XW     = 20;  // Horner accumulator width above the sample width

    localparam int NSTAGE = 8;

    typedef struct packed {
        logic diff;
        logic wsum;
        logic tang;
        logic coef;
    } t_tan_ctl;

    typedef struct packed {
        logic h1;
        logic h2;
        logic h3;
        logic outp;
    } t_hor_ctl;

    // Saturate a written register to +/- 1.0
    function automatic logic signed [CFG_DATA_W-1:0] clamp_q14(
        input logic signed [CFG_DATA_W-1:0] v);
        logic signed [CFG_DATA_W-1:0] r;
        if (v > Q14_ONE) begin
            r = Q14_ONE;
        end else if (v < -Q14_ONE) begin
            r = -Q14_ONE;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/chi_sample_if.sv */
// Input channel: four neighbouring samples and a fractional position
`default_nettype none
interface chi_sample_if import chi_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_before;
    logic [SAMPLE_BITS-1:0] sample_start;
    logic [SAMPLE_BITS-1:0] sample_end;
    logic [SAMPLE_BITS-1:0] sample_after;
    logic [FRAC_BITS-1:0]   fraction;

    modport source (
        output valid, sample_before, sample_start, sample_end, sample_after, fraction,
        input  ready
    );
    modport sink (
        input  valid, sample_before, sample_start, sample_end, sample_after, fraction,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/chi_result_if.sv */
// Output channel: interpolated sample and clip flag
`default_nettype none
interface chi_result_if import chi_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] interpolated;
    logic                   clipped;

    modport source (output valid, interpolated, clipped, input ready);
    modport sink   (input valid, interpolated, clipped, output ready);
endinterface
`default_nettype wire

/* rtl/chi_tangent.sv */
// Front stages: differences, weighted tangent sums, tangents and cubic coefficients
`default_nettype none
module chi_tangent import chi_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire t_tan_ctl                         i_ctl,
    input  wire logic signed [CFG_DATA_W-1:0]     i_bias,
    input  wire logic signed [CFG_DATA_W-1:0]     i_tension,
    input  wire logic [SAMPLE_BITS-1:0]           i_p0,
    input  wire logic [SAMPLE_BITS-1:0]           i_p1,
    input  wire logic [SAMPLE_BITS-1:0]           i_p2,
    input  wire logic [SAMPLE_BITS-1:0]           i_p3,
    input  wire logic [FRAC_BITS-1:0]             i_frac,
    output logic signed [SAMPLE_BITS+COEF_XW-1:0] o_c3,
    output logic signed [SAMPLE_BITS+COEF_XW-1:0] o_c2,
    output logic signed [SAMPLE_BITS+COEF_XW-1:0] o_c1,
    output logic [SAMPLE_BITS-1:0]                o_p1,
    output logic [FRAC_BITS-1:0]                  o_frac
);
    localparam int D_W  = SAMPLE_BITS + 1;
    localparam int PR_W = D_W + WGT_W;
    localparam int WS_W = SAMPLE_BITS + 17;
    localparam int TP_W = WS_W + WGT_W;
    localparam int M_W  = SAMPLE_BITS + 15;
    localparam int C_W  = SAMPLE_BITS + COEF_XW;

    logic signed [WGT_W-1:0] w_p, w_m, w_t;
    logic signed [WGT_W-1:0] e_bias, e_tens;

    // stage: differences
    logic signed [D_W-1:0] n_d0, n_d1, n_d2;
    logic signed [D_W-1:0] r_d0, r_d1, r_d2;
    logic [SAMPLE_BITS-1:0] r_p1_a;
    logic [FRAC_BITS-1:0]   r_f_a;

    // stage: weighted sums
    logic signed [PR_W-1:0] pr0, pr1, pr2, pr3;
    logic signed [PR_W-1:0] sum0, sum1;
    logic signed [WS_W-1:0] r_s0, r_s1;
    logic signed [D_W-1:0]  r_d1_b;
    logic [SAMPLE_BITS-1:0] r_p1_b;
    logic [FRAC_BITS-1:0]   r_f_b;

    // stage: tangents
    logic signed [TP_W-1:0] tp0, tp1, tr0, tr1;
    logic signed [M_W-1:0]  r_m0, r_m1;
    logic signed [D_W-1:0]  r_d1_c;
    logic [SAMPLE_BITS-1:0] r_p1_c;
    logic [FRAC_BITS-1:0]   r_f_c;

    // stage: coefficients
    logic signed [C_W-1:0]  e_m0, e_m1, e_dq, dq;
    logic signed [C_W-1:0]  n_c3, n_c2;
    logic signed [C_W-1:0]  r_c3, r_c2, r_c1;
    logic [SAMPLE_BITS-1:0] r_p1_d;
    logic [FRAC_BITS-1:0]   r_f_d;

    assign e_bias = WGT_W'(i_bias);
    assign e_tens = WGT_W'(i_tension);
    assign w_p = WGT_W'(Q14_ONE) + e_bias;
    assign w_m = WGT_W'(Q14_ONE) - e_bias;
    assign w_t = WGT_W'(Q14_ONE) - e_tens;

    assign n_d0 = $signed({1'b0, i_p1}) - $signed({1'b0, i_p0});
    assign n_d1 = $signed({1'b0, i_p2}) - $signed({1'b0, i_p1});
    assign n_d2 = $signed({1'b0, i_p3}) - $signed({1'b0, i_p2});

    always_ff @(posedge i_clk) begin
        if (i_ctl.diff) begin
            r_d0   <= n_d0;
            r_d1   <= n_d1;
            r_d2   <= n_d2;
            r_p1_a <= i_p1;
            r_f_a  <= i_frac;
        end
    end

    // earlier difference weighted by (1+bias), later one by (1-bias)
    assign pr0  = PR_W'(r_d0) * PR_W'(w_p);
    assign pr1  = PR_W'(r_d1) * PR_W'(w_m);
    assign pr2  = PR_W'(r_d1) * PR_W'(w_p);
    assign pr3  = PR_W'(r_d2) * PR_W'(w_m);
    assign sum0 = pr0 + pr1;
    assign sum1 = pr2 + pr3;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wsum) begin
            r_s0   <= sum0[WS_W-1:0];
            r_s1   <= sum1[WS_W-1:0];
            r_d1_b <= r_d1;
            r_p1_b <= r_p1_a;
            r_f_b  <= r_f_a;
        end
    end

    assign tp0 = TP_W'(r_s0) * TP_W'(w_t);
    assign tp1 = TP_W'(r_s1) * TP_W'(w_t);
    assign tr0 = tp0 + (TP_W'(1) <<< (TAN_SHIFT - 1));
    assign tr1 = tp1 + (TP_W'(1) <<< (TAN_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (i_ctl.tang) begin
            r_m0   <= tr0[TAN_SHIFT +: M_W];
            r_m1   <= tr1[TAN_SHIFT +: M_W];
            r_d1_c <= r_d1_b;
            r_p1_c <= r_p1_b;
            r_f_c  <= r_f_b;
        end
    end

    assign e_m0 = C_W'(r_m0);
    assign e_m1 = C_W'(r_m1);
    assign e_dq = C_W'(r_d1_c);
    assign dq   = e_dq <<< COEF_FRAC;
    assign n_c3 = e_m0 + e_m1 - (dq <<< 1);
    assign n_c2 = dq + (dq <<< 1) - (e_m0 <<< 1) - e_m1;

    always_ff @(posedge i_clk) begin
        if (i_ctl.coef) begin
            r_c3   <= n_c3;
            r_c2   <= n_c2;
            r_c1   <= e_m0;
            r_p1_d <= r_p1_c;
            r_f_d  <= r_f_c;
        end
    end

    assign o_c3   = r_c3;
    assign o_c2   = r_c2;
    assign o_c1   = r_c1;
    assign o_p1   = r_p1_d;
    assign o_frac = r_f_d;

endmodule
`default_nettype wire

/* rtl/chi_horner.sv */
// Back stages: three Horner steps, then rounding and saturation into the output register
`default_nettype none
module chi_horner import chi_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire                                        i_clk,
    input  wire t_hor_ctl                              i_ctl,
    input  wire logic signed [SAMPLE_BITS+COEF_XW-1:0] i_c3,
    input  wire logic signed [SAMPLE_BITS+COEF_XW-1:0] i_c2,
    input  wire logic signed [SAMPLE_BITS+COEF_XW-1:0] i_c1,
    input  wire logic [SAMPLE_BITS-1:0]                i_p1,
    input  wire logic [FRAC_BITS-1:0]                  i_frac,
    output logic [SAMPLE_BITS-1:0]                     o_interpolated,
    output logic                                       o_clipped
);
    localparam int C_W = SAMPLE_BITS + COEF_XW;
    localparam int A_W = SAMPLE_BITS + ACC_XW;
    localparam int P_W = A_W + FRAC_BITS + 1;

    // a * f, rounded half up by FRAC_BITS, plus the next coefficient
    function automatic logic signed [A_W-1:0] hstep(
        input logic signed [A_W-1:0] a,
        input logic [FRAC_BITS-1:0]  f,
        input logic signed [A_W-1:0] add);
        logic signed [P_W-1:0] prod;
        logic signed [P_W-1:0] rsum;
        prod = P_W'(a) * P_W'($signed({1'b0, f}));
        rsum = prod + (P_W'(1) <<< (FRAC_BITS - 1));
        return $signed(rsum[FRAC_BITS +: A_W]) + add;
    endfunction

    logic signed [A_W-1:0] e_c3, e_c2, e_c1, e_p1;
    logic signed [A_W-1:0] r_a1, r_a2, r_a3;
    logic signed [C_W-1:0] r_c1_a;
    logic [SAMPLE_BITS-1:0] r_p1_a, r_p1_b;
    logic [FRAC_BITS-1:0]   r_f_a, r_f_b;
    logic signed [A_W-1:0] yr;
    logic                  y_neg, y_over;
    logic [SAMPLE_BITS-1:0] n_res;
    logic                   n_clip;
    logic [SAMPLE_BITS-1:0] r_res;
    logic                   r_clip;

    assign e_c3 = A_W'(i_c3);
    assign e_c2 = A_W'(i_c2);
    assign e_c1 = A_W'(r_c1_a);
    assign e_p1 = $signed({{(A_W - SAMPLE_BITS){1'b0}}, r_p1_b}) <<< COEF_FRAC;

    always_ff @(posedge i_clk) begin
        if (i_ctl.h1) begin
            r_a1   <= hstep(e_c3, i_frac, e_c2);
            r_c1_a <= i_c1;
            r_p1_a <= i_p1;
            r_f_a  <= i_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.h2) begin
            r_a2   <= hstep(r_a1, r_f_a, e_c1);
            r_p1_b <= r_p1_a;
            r_f_b  <= r_f_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.h3) begin
            r_a3 <= hstep(r_a2, r_f_b, e_p1);
        end
    end

    // round off the coefficient fraction, then saturate to the sample range
    assign yr     = r_a3 + (A_W'(1) <<< (COEF_FRAC - 1));
    assign y_neg  = yr[A_W-1];
    assign y_over = |yr[A_W-2:COEF_FRAC+SAMPLE_BITS];

    always_comb begin
        priority if (y_neg) begin
            n_res  = '0;
            n_clip = 1'b1;
        end else if (y_over) begin
            n_res  = '1;
            n_clip = 1'b1;
        end else begin
            n_res  = yr[COEF_FRAC +: SAMPLE_BITS];
            n_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.outp) begin
            r_res  <= n_res;
            r_clip <= n_clip;
        end
    end

    assign o_interpolated = r_res;
    assign o_clipped      = r_clip;

endmodule
`default_nettype wire

/* rtl/cubic_hermite_interpolator.sv */
// Latency: eight register stages: differences, weighted sums, tangents, coefficients, three Horner steps, output.
// Throughput: one word per cycle while the output is not stalled.
// Each stage advances when its slot is empty or the next one moves, so bubbles collapse
// and a stalled output holds while earlier stages keep filling.
// Reset (synchronous, active low) clears the stage valid bits and sets bias and tension to 0.
`default_nettype none
`include "cubic_hermite_interpolator_defines.svh"
module cubic_hermite_interpolator import chi_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    chi_sample_if.sink                 i_smp,
    chi_result_if.source               o_res
);
    localparam int C_W = SAMPLE_BITS + COEF_XW;

    logic signed [CFG_DATA_W-1:0] r_bias, r_tension;
    logic signed [CFG_DATA_W-1:0] cfg_clamped;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] stage_en;

    t_tan_ctl tan_ctl;
    t_hor_ctl hor_ctl;

    logic signed [C_W-1:0]  c3, c2, c1;
    logic [SAMPLE_BITS-1:0] mid_p1;
    logic [FRAC_BITS-1:0]   mid_frac;

    // registers hold the clamped value
    assign cfg_clamped = clamp_q14($signed(i_cfg_data));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias    <= '0;
            r_tension <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BIAS:    r_bias    <= cfg_clamped;
                CFG_TENSION: r_tension <= cfg_clamped;
                default:     ;
            endcase
        end
    end

    // advance a stage when it is empty or its successor advances
    always_comb begin
        stage_en[NSTAGE-1] = !r_vld[NSTAGE-1] || o_res.ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            stage_en[i] = !r_vld[i] || stage_en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_smp.valid;
            end
            for (int i = 1; i < NSTAGE; i++) begin
                if (stage_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign tan_ctl = '{diff: stage_en[0], wsum: stage_en[1],
                       tang: stage_en[2], coef: stage_en[3]};
    assign hor_ctl = '{h1: stage_en[4], h2: stage_en[5],
                       h3: stage_en[6], outp: stage_en[7]};

    chi_tangent #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_tangent (
        .i_clk     (i_clk),
        .i_ctl     (tan_ctl),
        .i_bias    (r_bias),
        .i_tension (r_tension),
        .i_p0      (i_smp.sample_before),
        .i_p1      (i_smp.sample_start),
        .i_p2      (i_smp.sample_end),
        .i_p3      (i_smp.sample_after),
        .i_frac    (i_smp.fraction),
        .o_c3      (c3),
        .o_c2      (c2),
        .o_c1      (c1),
        .o_p1      (mid_p1),
        .o_frac    (mid_frac)
    );

    chi_horner #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_horner (
        .i_clk          (i_clk),
        .i_ctl          (hor_ctl),
        .i_c3           (c3),
        .i_c2           (c2),
        .i_c1           (c1),
        .i_p1           (mid_p1),
        .i_frac         (mid_frac),
        .o_interpolated (o_res.interpolated),
        .o_clipped      (o_res.clipped)
    );

    assign i_smp.ready = stage_en[0];
    assign o_res.valid = r_vld[NSTAGE-1];

    `CHI_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_smp.valid && i_smp.ready, r_vld[0], "accepted word did not enter the first stage")
    `CHI_ASSERT_IMPLY(a_ready_needs_bubble, i_clk, i_rst_n, i_smp.ready && !o_res.ready, !(&r_vld), "input ready with a full stalled pipeline")
    `CHI_ASSERT_IMPLY(a_clip_at_rail, i_clk, i_rst_n, o_res.valid && o_res.clipped, o_res.interpolated == '0 || o_res.interpolated == '1, "clipped result not at a rail")
    `CHI_ASSERT_IMPLY(a_cfg_in_range, i_clk, i_rst_n, 1'b1, r_bias <= Q14_ONE && r_bias >= -Q14_ONE && r_tension <= Q14_ONE && r_tension >= -Q14_ONE, "register beyond +/-1.0")

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench: cubic Hermite interpolator checked against a fixed-point predictor under random flow control
`timescale 1ns / 100ps
module tb;
    import chi_pkg::*;

    localparam int LIMIT_NS      = 2_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_WORDS   = 190;
    localparam int MAX_LOG       = 100;
    localparam int SMP_W         = SAMPLE_BITS_DEF;
    localparam int FRC_W         = FRAC_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    typedef enum int {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} t_gap_mode;

    typedef struct packed {
        logic [SMP_W-1:0] s_before;
        logic [SMP_W-1:0] s_start;
        logic [SMP_W-1:0] s_end;
        logic [SMP_W-1:0] s_after;
        logic [FRC_W-1:0] frac;
    } t_sample_word;

    typedef struct packed {
        logic [SMP_W-1:0] level;
        logic             clip;
    } t_result;

    typedef struct packed {
        t_sample_word w;
        logic         known;
        t_result      want;
    } t_directed_row;

    // Rows with a typed result run at the reset settings: flat data, fraction zero, clipping
    localparam int NUM_ROWS = 18;
    localparam t_directed_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0}},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1, '{16'hFFFF, 1'b0}},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'hFFFF, 1'b0}},
        '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0}},
        '{'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000}, 1'b1, '{16'hFFFF, 1'b1}},
        '{'{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000}, 1'b1, '{16'h0000, 1'b1}},
        '{'{16'd1234,  16'd5678,  16'd9012,  16'd3456,  16'h0000}, 1'b1, '{16'd5678, 1'b0}},
        '{'{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0}},
        '{'{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h4000}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'd100,   16'd200,   16'd300,   16'd400,   16'h8000}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'd40000, 16'd30000, 16'd50000, 16'd20000, 16'hFFFF}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hC000}, 1'b0, '{16'h0000, 1'b0}},
        '{'{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hC000}, 1'b0, '{16'h0000, 1'b0}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    chi_sample_if smp_ch ();
    chi_result_if res_ch ();

    cubic_hermite_interpolator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_smp      (smp_ch),
        .o_res      (res_ch)
    );

    // Mirror of the two tangent registers
    logic signed [CFG_DATA_W-1:0] bias_mirror    = '0;
    logic signed [CFG_DATA_W-1:0] tension_mirror = '0;

    t_result hermite_due [$];
    int      mismatches   = 0;
    int      results_seen = 0;
    int      clips_seen   = 0;
    int      src_gap_pct  = 0;
    int      rx_stall_pct = 0;
    int      hold_req     = 0;
    int      hold_ack     = 0;
    int      hold_left    = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Run stopped at the time limit with %0d results outstanding",
                 hermite_due.size());
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        // hold back the log after the first hundred
        if (mismatches <= MAX_LOG) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    function automatic longint limit_unit(input logic signed [CFG_DATA_W-1:0] r);
        longint v;
        v = longint'(r);
        if (v > 16384) begin
            v = 16384;
        end else if (v < -16384) begin
            v = -16384;
        end
        return v;
    endfunction

    // floor((x + half) / 2^s): halves go towards plus infinity
    function automatic longint round_shift(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic t_result hermite_eval(input t_sample_word w);
        longint  p0, p1, p2, p3, f;
        longint  wp, wm, tt, d0, d1, d2, m0, m1, dq, c3, c2, acc, y;
        t_result r;
        p0 = longint'(w.s_before);
        p1 = longint'(w.s_start);
        p2 = longint'(w.s_end);
        p3 = longint'(w.s_after);
        f  = longint'(w.frac);
        wp = 16384 + limit_unit(bias_mirror);
        wm = 16384 - limit_unit(bias_mirror);
        tt = 16384 - limit_unit(tension_mirror);
        d0 = p1 - p0;
        d1 = p2 - p1;
        d2 = p3 - p2;
        m0 = round_shift((d0 * wp + d1 * wm) * tt, TAN_SHIFT);
        m1 = round_shift((d1 * wp + d2 * wm) * tt, TAN_SHIFT);
        dq = d1 <<< COEF_FRAC;
        c3 = -2 * dq + m0 + m1;
        c2 = 3 * dq - 2 * m0 - m1;
        acc = round_shift(c3 * f, FRC_W) + c2;
        acc = round_shift(acc * f, FRC_W) + m0;
        acc = round_shift(acc * f, FRC_W) + (p1 <<< COEF_FRAC);
        y   = round_shift(acc, COEF_FRAC);
        if (y < 0) begin
            r.level = '0;
            r.clip  = 1'b1;
        end else if (y > longint'((1 << SMP_W) - 1)) begin
            r.level = '1;
            r.clip  = 1'b1;
        end else begin
            r.level = y[SMP_W-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [SMP_W-1:0] near_sample(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) begin
            v = 0;
        end else if (v > 65535) begin
            v = 65535;
        end
        return v[SMP_W-1:0];
    endfunction

    function automatic t_sample_word random_word();
        t_sample_word w;
        int           kind, base, spread, lo, hi;
        kind   = $urandom_range(9);
        base   = $urandom_range(65535);
        spread = 1 << $urandom_range(12);
        lo     = $urandom_range(65535);
        hi     = $urandom_range(65535);
        case (kind)
            0, 1, 2, 3: begin
                // smooth neighbourhood, as real sensor data looks
                w.s_before = near_sample(base, spread);
                w.s_start  = near_sample(int'(w.s_before), spread);
                w.s_end    = near_sample(int'(w.s_start), spread);
                w.s_after  = near_sample(int'(w.s_end), spread);
            end
            4, 5: begin
                w.s_before = SMP_W'($urandom_range(65535));
                w.s_start  = SMP_W'($urandom_range(65535));
                w.s_end    = SMP_W'($urandom_range(65535));
                w.s_after  = SMP_W'($urandom_range(65535));
            end
            6: begin
                w.s_before = ($urandom_range(1) != 0) ? '1 : '0;
                w.s_start  = ($urandom_range(1) != 0) ? '1 : '0;
                w.s_end    = ($urandom_range(1) != 0) ? '1 : '0;
                w.s_after  = ($urandom_range(1) != 0) ? '1 : '0;
            end
            7: begin
                w.s_before = lo[SMP_W-1:0];
                w.s_start  = near_sample(lo, 16);
                w.s_end    = hi[SMP_W-1:0];
                w.s_after  = near_sample(hi, 16);
            end
            8: begin
                // spike between the middle samples: drives overshoot
                w.s_before = lo[SMP_W-1:0];
                w.s_start  = hi[SMP_W-1:0];
                w.s_end    = near_sample(hi, spread);
                w.s_after  = near_sample(lo, spread);
            end
            default: begin
                w.s_before = base[SMP_W-1:0];
                w.s_start  = base[SMP_W-1:0];
                w.s_end    = base[SMP_W-1:0];
                w.s_after  = base[SMP_W-1:0];
            end
        endcase
        case ($urandom_range(19))
            0:       w.frac = '0;
            1:       w.frac = '1;
            2:       w.frac = 16'h8000;
            3:       w.frac = 16'h0001;
            default: w.frac = FRC_W'($urandom_range(65535));
        endcase
        return w;
    endfunction

    // Offer one word and wait for the handshake; log its expected result on acceptance
    task automatic send_word(input t_sample_word w, input logic known, input t_result typed);
        while ($urandom_range(99) < src_gap_pct) begin
            smp_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_ch.valid         <= 1'b1;
        smp_ch.sample_before <= w.s_before;
        smp_ch.sample_start  <= w.s_start;
        smp_ch.sample_end    <= w.s_end;
        smp_ch.sample_after  <= w.s_after;
        smp_ch.fraction      <= w.frac;
        do @(posedge i_clk); while (!smp_ch.ready);
        hermite_due.push_back(known ? typed : hermite_eval(w));
    endtask

    task automatic drain_results();
        smp_ch.valid <= 1'b0;
        while (hermite_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge i_clk);
        case (idx)
            CFG_BIAS:    bias_mirror    = d;
            CFG_TENSION: tension_mirror = d;
            default:     ;
        endcase
    endtask

    task automatic apply_settings(input logic signed [CFG_DATA_W-1:0] b,
                                  input logic signed [CFG_DATA_W-1:0] t);
        drain_results();
        write_reg(CFG_BIAS, b);
        write_reg(CFG_TENSION, t);
        // unused indexes must leave both registers alone
        write_reg(CFG_SPARE2, CFG_DATA_W'($urandom_range(65535)));
        write_reg(CFG_SPARE3, CFG_DATA_W'($urandom_range(65535)));
        cfg_we <= 1'b0;
    endtask

    // Receiver: random stalls, one long hold on request, and the result check
    always @(posedge i_clk) begin : rx_side
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (res_ch.clipped) begin
                clips_seen++;
            end
            if (hermite_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word: level %0h clip %0b",
                                          res_ch.interpolated, res_ch.clipped));
            end else begin
                want = hermite_due.pop_front();
                if (res_ch.interpolated !== want.level) begin
                    report_mismatch($sformatf("result %0d level: got %0h, expected %0h",
                                              results_seen, res_ch.interpolated, want.level));
                end
                if (res_ch.clipped !== want.clip) begin
                    report_mismatch($sformatf("result %0d clip: got %0b, expected %0b",
                                              results_seen, res_ch.clipped, want.clip));
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end
        res_ch.ready <= (hold_left == 0) && (hold_req == hold_ack) &&
                        ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin : stimulus
        logic signed [CFG_DATA_W-1:0] b, t;
        t_gap_mode                    mode;
        int                           random_words;
        int                           settings_used;
        random_words  = 0;
        settings_used = 0;
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_BIAS;
        cfg_data             <= '0;
        smp_ch.valid         <= 1'b0;
        smp_ch.sample_before <= '0;
        smp_ch.sample_start  <= '0;
        smp_ch.sample_end    <= '0;
        smp_ch.sample_after  <= '0;
        smp_ch.fraction      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // table at the reset settings
        for (int r = 0; r < NUM_ROWS; r++) begin
            send_word(DIRECTED_ROWS[r].w, DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin b = '0;        t = '0;        end
                1: begin b = Q14_ONE;   t = Q14_ONE;   end
                2: begin b = -Q14_ONE;  t = -Q14_ONE;  end
                3: begin b = 16'sh7FFF; t = 16'sh8000; end
                4: begin b = 16'sh8000; t = 16'sh7FFF; end
                7: begin b = Q14_ONE;   t = -Q14_ONE;  end
                default: begin
                    b = CFG_DATA_W'(int'($urandom_range(32768)) - 16384);
                    t = CFG_DATA_W'(int'($urandom_range(32768)) - 16384);
                end
            endcase
            apply_settings(b, t);
            settings_used++;
            mode = t_gap_mode'(ph % 4);
            src_gap_pct  = (mode == GAP_SENDER)   ? 75 : (mode == GAP_BOTH) ? 24 : 0;
            rx_stall_pct = (mode == GAP_RECEIVER) ? 75 : (mode == GAP_BOTH) ? 24 : 0;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (ph == 4 && k == 50) begin
                    // hold the output while the sender keeps offering words
                    hold_req++;
                end
                if (ph == 6 && k == PHASE_WORDS / 2) begin
                    drain_results();
                end
                send_word(random_word(), 1'b0, '0);
                random_words++;
            end
        end

        drain_results();
        rx_stall_pct = 0;
        repeat (20) @(posedge i_clk);
        $display("Ran %0d table rows and %0d random words through %0d register settings",
                 NUM_ROWS, random_words, settings_used + 1);
        $display("Checked %0d results, %0d clipped, with one %0d-cycle output hold",
                 results_seen, clips_seen, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/chi_pkg.sv
rtl/chi_sample_if.sv
rtl/chi_result_if.sv
rtl/chi_tangent.sv
rtl/chi_horner.sv
rtl/cubic_hermite_interpolator.sv
verif/tb.sv
